[rtl/core/lal_pkg.sv]
// Shared widths, register codes and stage count for the longitudinal aero loads block.
package lal_pkg;

  localparam int unsigned IN_W    = 16;  // airspeed, angle, density
  localparam int unsigned COEF_W  = 16;  // Q4.12 coefficients
  localparam int unsigned CHORD_W = 16;  // Q8.8 chord
  localparam int unsigned AREA_W  = 24;  // Q16.8 area
  localparam int unsigned CFG_W   = 24;  // widest register
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned OUT_W   = 48;

  localparam int unsigned VV_W    = 32;  // v^2
  localparam int unsigned RV_W    = 48;  // rho*v^2
  localparam int unsigned Q16_W   = 32;  // dynamic pressure, scale 2^-16
  localparam int unsigned WIDE_W  = 32;  // c0*2^13 + slope*alpha
  localparam int unsigned C12_W   = 20;  // rounded coefficient, signed
  localparam int unsigned CMAG_W  = 19;  // coefficient magnitude
  localparam int unsigned CSQ_W   = 36;  // CL^2
  localparam int unsigned QS_W    = 56;  // q16*S
  localparam int unsigned KCL_W   = 52;  // k*CL^2
  localparam int unsigned QA_W    = 40;  // q*S, scale 2^-8
  localparam int unsigned CD_W    = 29;  // drag coefficient
  localparam int unsigned QAC_W   = 56;  // qa8*c
  localparam int unsigned QAC8_W  = 48;  // q*S*c, scale 2^-8

  // Front stages in the top level, back stages in each output scaler
  localparam int unsigned FRONT_STAGES = 7;
  localparam int unsigned SCALE_STAGES = 4;
  localparam int unsigned N_STAGES     = FRONT_STAGES + SCALE_STAGES;

  localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

  localparam logic [CHORD_W-1:0] CHORD_RESET = 16'd256;
  localparam logic [AREA_W-1:0]  AREA_RESET  = 24'd256;

  typedef enum logic [IDX_W-1:0] {
    REG_LIFT0  = 3'd0,
    REG_LIFTS  = 3'd1,
    REG_CD0    = 3'd2,
    REG_KIND   = 3'd3,
    REG_PITCH0 = 3'd4,
    REG_PITCHS = 3'd5,
    REG_CHORD  = 3'd6,
    REG_AREA   = 3'd7
  } lal_reg_t;

endpackage

[rtl/core/lal_if.sv]
// Request and result channel interfaces for the aero loads block.
interface lal_in_if import lal_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic        [IN_W-1:0]  airspeed;
  logic signed [IN_W-1:0]  attack_angle;
  logic        [IN_W-1:0]  air_density;

  modport source (output valid, airspeed, attack_angle, air_density, input ready);
  modport sink   (input valid, airspeed, attack_angle, air_density, output ready);
endinterface

interface lal_out_if import lal_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] drag_force;
  logic signed [OUT_W-1:0] lift_force;
  logic signed [OUT_W-1:0] pitch_moment;
  logic                    input_error;

  modport source (output valid, drag_force, lift_force, pitch_moment, input_error,
                  input ready);
  modport sink   (input valid, drag_force, lift_force, pitch_moment, input_error,
                  output ready);
endinterface

[rtl/core/longitudinal_aero_loads_top.sv]
// Top level of the longitudinal aero loads pipeline.
//
// Usage: each request on in_ch carries airspeed (Q8.8 m/s), angle of attack
// (Q2.13 rad) and air density (Q1.15). One result leaves on out_ch for every
// request, in order: drag_force (negative), lift_force and pitch_moment in
// sixteenths of a newton (meter), saturated to 48 bits, plus input_error.
// Zero density flags input_error; all three loads then come out as zero.
// Each accepted request passes seven front stages (v^2 and coefficients,
// rho*v^2, q and CL^2, q*S and k*CL^2, CD, q*S*c, rounded q*S*c) and four
// stages in each output scaler (split product, sum, round/saturate, sign).
// Throughput is one request per cycle unless the output stalls; the
// multiplier chain for q*S*c is the longest path and sets the depth.
// The pipeline advances as one unit: when the output register holds a
// result the receiver has not taken, every stage and in_ch.ready hold, so
// nothing is lost or repeated. Bubbles travel as cleared valid bits.
// Coefficient registers must be written via cfg_we/cfg_index/cfg_data only
// while the pipeline is empty; the block does not enforce this. Synchronous
// reset clears valid bits, sets chord and area to 1.0, coefficients to 0.
module longitudinal_aero_loads_top import lal_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  lal_in_if.sink           in_ch,
  lal_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // ---------------- configuration registers ----------------
  logic signed [COEF_W-1:0]  cl0_r, cla_r, cm0_r, cma_r;
  logic        [COEF_W-1:0]  cd0_r, kind_r;
  logic        [CHORD_W-1:0] chord_r;
  logic        [AREA_W-1:0]  area_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl0_r   <= '0;
      cla_r   <= '0;
      cd0_r   <= '0;
      kind_r  <= '0;
      cm0_r   <= '0;
      cma_r   <= '0;
      chord_r <= CHORD_RESET;
      area_r  <= AREA_RESET;
    end else if (cfg_we) begin
      unique case (lal_reg_t'(cfg_index))
        REG_LIFT0:  cl0_r   <= cfg_data[COEF_W-1:0];
        REG_LIFTS:  cla_r   <= cfg_data[COEF_W-1:0];
        REG_CD0:    cd0_r   <= cfg_data[COEF_W-1:0];
        REG_KIND:   kind_r  <= cfg_data[COEF_W-1:0];
        REG_PITCH0: cm0_r   <= cfg_data[COEF_W-1:0];
        REG_PITCHS: cma_r   <= cfg_data[COEF_W-1:0];
        REG_CHORD:  chord_r <= cfg_data[CHORD_W-1:0];
        REG_AREA:   area_r  <= cfg_data[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic                en;
  logic [N_STAGES-1:0] vld_r, err_r;

  // advance unless a finished result is still waiting at the output
  assign en          = !vld_r[N_STAGES-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N_STAGES-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_r <= {err_r[N_STAGES-2:0], (in_ch.air_density == '0)};
    end
  end

  // ---------------- stage 1: v^2 and coefficient products ----------------
  logic        [VV_W-1:0]   vv_r, vv_nxt;
  logic        [IN_W-1:0]   rho1_r;
  logic signed [WIDE_W-1:0] wl_r, wl_nxt, wm_r, wm_nxt;

  // sign-extend both factors first so the full slope*alpha product is kept
  assign vv_nxt = VV_W'(in_ch.airspeed) * VV_W'(in_ch.airspeed);
  assign wl_nxt = {{3{cl0_r[COEF_W-1]}}, cl0_r, 13'd0}
                + (WIDE_W'(cla_r) * WIDE_W'(in_ch.attack_angle));
  assign wm_nxt = {{3{cm0_r[COEF_W-1]}}, cm0_r, 13'd0}
                + (WIDE_W'(cma_r) * WIDE_W'(in_ch.attack_angle));

  // ---------------- stage 2: rho*v^2, round coefficients ----------------
  logic        [RV_W-1:0]   rv_r, rv_nxt;
  logic signed [C12_W-1:0]  cl2_r, cl_nxt, cm2_r, cm_nxt;
  logic        [WIDE_W:0]   wl_rnd, wm_rnd;

  assign rv_nxt = RV_W'(rho1_r) * RV_W'(vv_r);
  assign wl_rnd = {wl_r[WIDE_W-1], wl_r} + (WIDE_W+1)'(4096);
  assign wm_rnd = {wm_r[WIDE_W-1], wm_r} + (WIDE_W+1)'(4096);
  assign cl_nxt = wl_rnd[WIDE_W:13];
  assign cm_nxt = wm_rnd[WIDE_W:13];

  // ---------------- stage 3: q16, CL^2, magnitudes ----------------
  logic [Q16_W-1:0]        q16_r, q16_nxt;
  logic [RV_W:0]           q_rnd;
  logic signed [2*C12_W-1:0] clsq_full;
  logic [CSQ_W-1:0]        clsq_r, clsq_nxt;
  logic [C12_W-1:0]        cl_abs, cm_abs;
  logic [CMAG_W-1:0]       clm3_r, cmm3_r;
  logic                    cln3_r, cmn3_r;

  assign q_rnd     = {1'b0, rv_r} + (RV_W+1)'(32'h8000);
  assign q16_nxt   = q_rnd[RV_W-1:16];
  assign clsq_full = (2*C12_W)'(cl2_r) * (2*C12_W)'(cl2_r);
  assign clsq_nxt  = clsq_full[CSQ_W-1:0];
  assign cl_abs    = cl2_r[C12_W-1] ? (C12_W'(0) - cl2_r) : cl2_r;
  assign cm_abs    = cm2_r[C12_W-1] ? (C12_W'(0) - cm2_r) : cm2_r;

  // ---------------- stage 4: q*S and k*CL^2 products ----------------
  logic [QS_W-1:0]   qs_r, qs_nxt;
  logic [KCL_W-1:0]  kcl_r, kcl_nxt;
  logic [CMAG_W-1:0] clm4_r, cmm4_r;
  logic              cln4_r, cmn4_r;

  assign qs_nxt  = QS_W'(q16_r) * QS_W'(area_r);
  assign kcl_nxt = KCL_W'(kind_r) * KCL_W'(clsq_r);

  // ---------------- stage 5: round q*S, form CD ----------------
  logic [QA_W-1:0]   qa5_r, qa_nxt;
  logic [CD_W-1:0]   cd5_r, cd_nxt;
  logic [QS_W:0]     qs_rnd;
  logic [KCL_W:0]    kcl_rnd;
  logic [CMAG_W-1:0] clm5_r, cmm5_r;
  logic              cln5_r, cmn5_r;

  assign qs_rnd  = {1'b0, qs_r} + (QS_W+1)'(32'h8000);
  assign qa_nxt  = qs_rnd[QS_W-1:16];
  assign kcl_rnd = {1'b0, kcl_r} + (KCL_W+1)'(32'h800000);
  assign cd_nxt  = CD_W'(cd0_r) + CD_W'(kcl_rnd[KCL_W-1:24]);

  // ---------------- stage 6: q*S*c product ----------------
  logic [QAC_W-1:0]  qac_r, qac_nxt;
  logic [QA_W-1:0]   qa6_r;
  logic [CD_W-1:0]   cd6_r;
  logic [CMAG_W-1:0] clm6_r, cmm6_r;
  logic              cln6_r, cmn6_r;

  assign qac_nxt = QAC_W'(qa5_r) * QAC_W'(chord_r);

  // ---------------- stage 7: round q*S*c ----------------
  logic [QAC8_W-1:0] qac8_r, qac8_nxt;
  logic [QAC_W:0]    qac_rnd;
  logic [QA_W-1:0]   qa7_r;
  logic [CD_W-1:0]   cd7_r;
  logic [CMAG_W-1:0] clm7_r, cmm7_r;
  logic              cln7_r, cmn7_r;

  assign qac_rnd  = {1'b0, qac_r} + (QAC_W+1)'(8'h80);
  assign qac8_nxt = qac_rnd[QAC_W-1:8];

  always_ff @(posedge clk) begin
    if (en) begin
      vv_r   <= vv_nxt;
      rho1_r <= in_ch.air_density;
      wl_r   <= wl_nxt;
      wm_r   <= wm_nxt;

      rv_r   <= rv_nxt;
      cl2_r  <= cl_nxt;
      cm2_r  <= cm_nxt;

      q16_r  <= q16_nxt;
      clsq_r <= clsq_nxt;
      clm3_r <= cl_abs[CMAG_W-1:0];
      cmm3_r <= cm_abs[CMAG_W-1:0];
      cln3_r <= cl2_r[C12_W-1];
      cmn3_r <= cm2_r[C12_W-1];

      qs_r   <= qs_nxt;
      kcl_r  <= kcl_nxt;
      clm4_r <= clm3_r;
      cmm4_r <= cmm3_r;
      cln4_r <= cln3_r;
      cmn4_r <= cmn3_r;

      qa5_r  <= qa_nxt;
      cd5_r  <= cd_nxt;
      clm5_r <= clm4_r;
      cmm5_r <= cmm4_r;
      cln5_r <= cln4_r;
      cmn5_r <= cmn4_r;

      qac_r  <= qac_nxt;
      qa6_r  <= qa5_r;
      cd6_r  <= cd5_r;
      clm6_r <= clm5_r;
      cmm6_r <= cmm5_r;
      cln6_r <= cln5_r;
      cmn6_r <= cmn5_r;

      qac8_r <= qac8_nxt;
      qa7_r  <= qa6_r;
      cd7_r  <= cd6_r;
      clm7_r <= clm6_r;
      cmm7_r <= cmm6_r;
      cln7_r <= cln6_r;
      cmn7_r <= cmn6_r;
    end
  end

  // ---------------- output scalers ----------------
  // drag is always reported negative; a zero magnitude stays zero
  lal_scale #(.AW(QA_W), .BW(CD_W)) u_drag (
    .clk (clk),
    .en  (en),
    .a   (qa7_r),
    .b   (cd7_r),
    .neg (1'b1),
    .res (out_ch.drag_force)
  );

  lal_scale #(.AW(QA_W), .BW(CMAG_W)) u_lift (
    .clk (clk),
    .en  (en),
    .a   (qa7_r),
    .b   (clm7_r),
    .neg (cln7_r),
    .res (out_ch.lift_force)
  );

  lal_scale #(.AW(QAC8_W), .BW(CMAG_W)) u_pitch (
    .clk (clk),
    .en  (en),
    .a   (qac8_r),
    .b   (cmm7_r),
    .neg (cmn7_r),
    .res (out_ch.pitch_moment)
  );

  assign out_ch.valid       = vld_r[N_STAGES-1];
  assign out_ch.input_error = err_r[N_STAGES-1];

`ifndef ASSERT_OFF
  // zero density drives q to zero, so every load must come out zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.input_error |->
      out_ch.drag_force == '0 && out_ch.lift_force == '0 && out_ch.pitch_moment == '0)
    else $error("nonzero load on zero-density result");

  // drag result never positive
  a_drag_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.drag_force[OUT_W-1] || out_ch.drag_force == '0)
    else $error("positive drag force");

  // pipeline is empty on the first cycle after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");
`endif

endmodule

[rtl/core/lal_scale.sv]
// Output scaler: magnitude product, round half up by 2^16, saturate, apply sign.
module lal_scale import lal_pkg::*; #(
  parameter int unsigned AW = 40,
  parameter int unsigned BW = 19
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [AW-1:0]           a,
  input  logic [BW-1:0]           b,
  input  logic                    neg,
  output logic signed [OUT_W-1:0] res
);

  localparam int unsigned AL = AW / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned RW = PW - 15;
  localparam int unsigned XW = (RW > OUT_W) ? RW : OUT_W;

  logic [AL+BW-1:0] plo_r, plo_nxt;
  logic [AH+BW-1:0] phi_r, phi_nxt;
  logic             neg_a_r, neg_b_r, neg_c_r;
  logic [PW-1:0]    sum_r, sum_nxt;
  logic [PW:0]      rnd;
  logic [XW-1:0]    shifted;
  logic             over;
  logic [OUT_W-1:0] limit;
  logic [OUT_W-1:0] mag_r, mag_nxt;
  logic [OUT_W-1:0] res_r, res_nxt;

  // split the wide operand into halves so no single multiplier takes all of it
  assign plo_nxt = (AL+BW)'(a[AL-1:0]) * (AL+BW)'(b);
  assign phi_nxt = (AH+BW)'(a[AW-1:AL]) * (AH+BW)'(b);
  assign sum_nxt = PW'(plo_r) + (PW'(phi_r) << AL);

  assign rnd     = {1'b0, sum_r} + (PW+1)'(32'h8000);
  assign shifted = XW'(rnd[PW:16]);
  assign limit   = neg_b_r ? NEG_LIMIT : POS_LIMIT;
  assign over    = shifted > XW'(limit);
  assign mag_nxt = over ? limit : shifted[OUT_W-1:0];

  assign res_nxt = neg_c_r ? (OUT_W'(0) - mag_r) : mag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r   <= plo_nxt;
      phi_r   <= phi_nxt;
      neg_a_r <= neg;
      sum_r   <= sum_nxt;
      neg_b_r <= neg_a_r;
      mag_r   <= mag_nxt;
      neg_c_r <= neg_b_r;
      res_r   <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
